/* hdl/rwrb_pkg.sv */
// Shared types and constants for the receive window reorder buffer.
// Used by the front end, the back end and the top level; depends on nothing else.
package rwrb_pkg;

    // Fixed field widths.
    localparam int ID_W        = 16;
    localparam int HANDLE_BITS = 32;
    localparam int STATUS_W    = 3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OLD       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DESYNC    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_SKIPPED   = 3'd7;

    // Input item.
    typedef struct packed {
        logic                   action;
        logic [ID_W-1:0]        message_id;
        logic [HANDLE_BITS-1:0] payload_handle;
        logic                   last_in_packet;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ID_W-1:0]        delivered_id;
        logic [HANDLE_BITS-1:0] delivered_payload;
    } t_out;

    // Slot memory operation handed from the front to the back.
    typedef struct packed {
        logic                   is_pull;
        logic [ID_W-1:0]        id;
        logic [HANDLE_BITS-1:0] handle;
    } t_op;

    // One slot memory entry.
    typedef struct packed {
        logic                   valid;
        logic [ID_W-1:0]        id;
        logic [HANDLE_BITS-1:0] payload;
    } t_slot;

    // Completion report from the back to the front.
    typedef struct packed {
        logic done;
        logic delivered;
    } t_done;

endpackage

/* hdl/rwrb_front.sv */
// Front end of the reorder buffer: accepts items, keeps the window state and
// settles every item that needs no slot lookup. Depends on rwrb_pkg.
module rwrb_front #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int SLOT_W       = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  rwrb_pkg::t_in       i_item,
    input  logic                i_clearing,
    input  rwrb_pkg::t_done     i_done,
    output logic                o_busy,
    output logic                o_push,
    output rwrb_pkg::t_op       o_push_op,
    output logic [SLOT_W-1:0]   o_push_slot,
    output logic                o_res_valid,
    output rwrb_pkg::t_out      o_res
);

    localparam logic [rwrb_pkg::ID_W-1:0] TOP_OFS   = rwrb_pkg::ID_W'(WINDOW_DEPTH - 1);
    localparam logic [SLOT_W-1:0]         SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [SLOT_W:0]           DEPTH_EXT = (SLOT_W + 1)'(WINDOW_DEPTH);
    localparam logic [rwrb_pkg::ID_W-1:0] ID_MAX    = '1;

    // True when a is later than b under 16-bit wraparound.
    function automatic logic seq_later(input logic [rwrb_pkg::ID_W-1:0] a,
                                       input logic [rwrb_pkg::ID_W-1:0] b);
        logic [rwrb_pkg::ID_W-1:0] d_ab;
        logic [rwrb_pkg::ID_W-1:0] d_ba;
        d_ab = a - b;
        d_ba = b - a;
        return ((a > b) && (d_ab <= 16'h8000)) || ((a < b) && (d_ba > 16'h8000));
    endfunction

    logic [rwrb_pkg::ID_W-1:0] r_next;
    logic [rwrb_pkg::ID_W-1:0] n_next;
    logic [SLOT_W-1:0]         r_next_slot;
    logic [SLOT_W-1:0]         n_next_slot;
    logic                      r_desync;
    logic                      n_desync;
    logic                      r_skip;
    logic                      n_skip;
    logic                      r_pending;
    logic                      n_pending;
    logic                      r_res_valid;
    logic                      n_res_valid;
    rwrb_pkg::t_out            r_res;
    rwrb_pkg::t_out            n_res;

    logic                      w_accept;
    logic [rwrb_pkg::ID_W-1:0] w_top;
    logic [rwrb_pkg::ID_W-1:0] w_k;
    logic [SLOT_W:0]           w_sum;
    logic [SLOT_W-1:0]         w_arr_slot;

    assign o_busy   = r_pending | i_clearing;
    assign w_accept = i_start & ~o_busy;

    // Slot of an in-window arrival, found from its offset to the expected id.
    // An id that has wrapped past zero is below the depth and is its own slot.
    assign w_top = r_next + TOP_OFS;
    assign w_k   = i_item.message_id - r_next;
    assign w_sum = {1'b0, r_next_slot} + {1'b0, w_k[SLOT_W-1:0]};
    always_comb begin
        if (i_item.message_id < r_next) begin
            w_arr_slot = i_item.message_id[SLOT_W-1:0];
        end else if (w_sum >= DEPTH_EXT) begin
            w_arr_slot = SLOT_W'(w_sum - DEPTH_EXT);
        end else begin
            w_arr_slot = w_sum[SLOT_W-1:0];
        end
    end

    // Classification of the accepted item and window state update.
    always_comb begin
        n_next      = r_next;
        n_next_slot = r_next_slot;
        n_desync    = r_desync;
        n_skip      = r_skip;
        n_pending   = r_pending;
        n_res_valid = 1'b0;
        n_res       = '0;
        o_push      = 1'b0;
        o_push_op   = '{is_pull: i_item.action, id: i_item.message_id,
                        handle: i_item.payload_handle};
        o_push_slot = w_arr_slot;

        if (i_done.done) begin
            n_pending = 1'b0;
            if (i_done.delivered) begin
                n_next = r_next + 1'b1;
                if (r_next == ID_MAX || r_next_slot == SLOT_LAST) begin
                    n_next_slot = '0;
                end else begin
                    n_next_slot = r_next_slot + 1'b1;
                end
            end
        end

        if (w_accept) begin
            if (i_item.action) begin
                if (r_desync) begin
                    n_res_valid = 1'b1;
                    n_res.status = rwrb_pkg::ST_BLOCKED;
                end else begin
                    o_push       = 1'b1;
                    o_push_op.id = r_next;
                    o_push_slot  = r_next_slot;
                    n_pending    = 1'b1;
                end
            end else if (r_skip) begin
                n_res_valid  = 1'b1;
                n_res.status = rwrb_pkg::ST_SKIPPED;
                if (i_item.last_in_packet) begin
                    n_skip = 1'b0;
                end
            end else if (seq_later(r_next, i_item.message_id)) begin
                n_res_valid  = 1'b1;
                n_res.status = rwrb_pkg::ST_OLD;
            end else if (seq_later(i_item.message_id, w_top)) begin
                n_res_valid  = 1'b1;
                n_res.status = rwrb_pkg::ST_DESYNC;
                n_desync     = 1'b1;
                n_skip       = ~i_item.last_in_packet;
            end else begin
                o_push    = 1'b1;
                n_pending = 1'b1;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next      <= '0;
            r_next_slot <= '0;
            r_desync    <= 1'b0;
            r_skip      <= 1'b0;
            r_pending   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_next      <= n_next;
            r_next_slot <= n_next_slot;
            r_desync    <= n_desync;
            r_skip      <= n_skip;
            r_pending   <= n_pending;
            r_res_valid <= n_res_valid;
        end
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* hdl/rwrb_queue.sv */
// Two-entry queue that carries slot operations from the front to the back.
// Depends on nothing but its width parameter.
module rwrb_queue #(
    parameter int W = 60
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic [1:0]   n_count;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hdl/rwrb_back.sv */
// Back end of the reorder buffer: owns the slot memory, clears it after reset
// and performs the read-check-write of each queued operation. Depends on rwrb_pkg.
module rwrb_back #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int SLOT_W       = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  rwrb_pkg::t_op     i_q_op,
    input  logic [SLOT_W-1:0] i_q_slot,
    output logic              o_pop,
    output logic              o_clearing,
    output rwrb_pkg::t_done   o_done,
    output logic              o_res_valid,
    output rwrb_pkg::t_out    o_res
);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

    rwrb_pkg::t_slot   r_mem [WINDOW_DEPTH];
    rwrb_pkg::t_slot   r_rd;
    rwrb_pkg::t_op     r_op;
    logic [SLOT_W-1:0] r_slot;
    logic              r_phase;
    logic              r_clearing;
    logic [SLOT_W-1:0] r_clr_idx;
    logic              r_res_valid;
    rwrb_pkg::t_out    r_res;
    rwrb_pkg::t_out    n_res;

    logic              w_hit;
    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    rwrb_pkg::t_slot   w_wdata;

    assign o_clearing = r_clearing;
    assign o_pop      = i_q_valid & ~r_clearing & ~r_phase;
    assign w_hit      = r_rd.valid && (r_rd.id == r_op.id);

    // Check the slot read last cycle and decide the write and the result.
    always_comb begin
        w_we           = 1'b0;
        w_waddr        = r_slot;
        w_wdata        = '{valid: 1'b1, id: r_op.id, payload: r_op.handle};
        n_res          = '0;
        o_done.done      = r_phase;
        o_done.delivered = 1'b0;
        if (r_clearing) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            w_wdata = '0;
        end else if (r_phase) begin
            if (r_op.is_pull) begin
                if (w_hit) begin
                    w_we                    = 1'b1;
                    w_wdata                 = r_rd;
                    w_wdata.valid           = 1'b0;
                    n_res.status            = rwrb_pkg::ST_DELIVERED;
                    n_res.delivered_id      = r_op.id;
                    n_res.delivered_payload = r_rd.payload;
                    o_done.delivered        = 1'b1;
                end else begin
                    n_res.status = rwrb_pkg::ST_NONE;
                end
            end else if (w_hit) begin
                n_res.status = rwrb_pkg::ST_DUP;
            end else begin
                w_we         = 1'b1;
                n_res.status = rwrb_pkg::ST_STORED;
            end
        end
    end

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (o_pop) begin
            r_rd <= r_mem[i_q_slot];
        end
    end

    // Control: clearing pass after reset, then one operation at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_phase     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_phase & ~r_clearing;
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == SLOT_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            if (o_pop) begin
                r_phase <= 1'b1;
            end else if (r_phase) begin
                r_phase <= 1'b0;
            end
        end
        if (o_pop) begin
            r_op   <= i_q_op;
            r_slot <= i_q_slot;
        end
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* hdl/receive_window_reorder_buffer.sv */
// Top level of the receive window reorder buffer.
// Instantiates rwrb_front, rwrb_queue and rwrb_back; depends on rwrb_pkg.
//
// An item is taken when start is high and busy is low; its result appears on
// o_result for one cycle with o_strobe high and cannot be held off. Pulls
// while in desync, skipped arrivals, old ids and out-of-window ids are settled
// from the window registers: result in the cycle after acceptance, and the next
// item may follow in the next cycle. Arrivals inside the window and pulls that
// are not blocked go through the slot memory's read-check-write: the result
// follows the hop through the operation queue, the registered slot read and the
// check and write that follows it, and busy stays high until the check is done,
// so the next item waits for it. After reset busy stays high for a clearing pass
// that invalidates every slot.
module receive_window_reorder_buffer #(
    parameter int WINDOW_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  rwrb_pkg::t_in    i_item,
    output logic             busy,
    output logic             o_strobe,
    output rwrb_pkg::t_out   o_result
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int Q_W    = $bits(rwrb_pkg::t_op) + SLOT_W;

    logic              w_push;
    rwrb_pkg::t_op     w_push_op;
    logic [SLOT_W-1:0] w_push_slot;
    logic              w_pop;
    logic              w_q_valid;
    logic [Q_W-1:0]    w_q_data;
    logic              w_clearing;
    rwrb_pkg::t_done   w_done;
    logic              w_f_valid;
    rwrb_pkg::t_out    w_f_res;
    logic              w_b_valid;
    rwrb_pkg::t_out    w_b_res;

    // Front end: acceptance and classification.
    rwrb_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SLOT_W       (SLOT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_clearing  (w_clearing),
        .i_done      (w_done),
        .o_busy      (busy),
        .o_push      (w_push),
        .o_push_op   (w_push_op),
        .o_push_slot (w_push_slot),
        .o_res_valid (w_f_valid),
        .o_res       (w_f_res)
    );

    // Operation queue between the two halves.
    rwrb_queue #(
        .W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_slot, w_push_op}),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // Back end: slot memory access.
    rwrb_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SLOT_W       (SLOT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_op      (w_q_data[$bits(rwrb_pkg::t_op)-1:0]),
        .i_q_slot    (w_q_data[Q_W-1:$bits(rwrb_pkg::t_op)]),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_done      (w_done),
        .o_res_valid (w_b_valid),
        .o_res       (w_b_res)
    );

    // Both halves deliver registered results; they never coincide.
    assign o_strobe = w_f_valid | w_b_valid;
    assign o_result = w_b_valid ? w_b_res : w_f_res;

`ifndef SYNTH
    // Front and back never present a result in the same cycle.
    a_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_f_valid && w_b_valid))
        else $error("front and back results collide");

    // A memory result only follows an operation that held the block busy.
    a_back_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_b_valid |-> $past(busy))
        else $error("back result without an outstanding operation");

    // Nothing is queued while the slot memory is being cleared.
    a_no_push_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !w_push)
        else $error("operation queued during clearing pass");

    // A delivery report always comes with a completion.
    a_delivered_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done.delivered |-> w_done.done)
        else $error("delivery reported outside completion");
`endif

endmodule

/* bench/tb_receive_window_reorder_buffer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for receive_window_reorder_buffer: ordered bursts of
// arrivals and pulls, then desync and skip handling; depends on rwrb_pkg.
module tb_receive_window_reorder_buffer;

    localparam int WIN_DEPTH      = 1024;
    localparam int ITEMS_ORDERED  = 1250;
    localparam int ITEMS_TOTAL    = 1550;
    localparam int WATCHDOG_LIMIT = 5000;

    // Action codes of an input item.
    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_PULL   = 1'b1;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    rwrb_pkg::t_in  stim = '0;
    logic           busy;
    logic           o_strobe;
    rwrb_pkg::t_out o_result;

    // Window state as the block should hold it.
    logic [rwrb_pkg::ID_W-1:0]        win_next = '0;
    logic                             win_desync = 1'b0;
    logic                             win_skip = 1'b0;
    logic                             slot_held [WIN_DEPTH];
    logic [rwrb_pkg::ID_W-1:0]        slot_tag [WIN_DEPTH];
    logic [rwrb_pkg::HANDLE_BITS-1:0] slot_data [WIN_DEPTH];

    rwrb_pkg::t_in  pending_items [$];
    rwrb_pkg::t_out expected_results [$];
    int   items_queued = 0;
    int   mismatches = 0;
    int   idle_cycles = 0;
    int   gap_left = 0;
    int   taken_count = 0;
    int   seen_count = 0;
    logic stim_go = 1'b0;
    logic no_idle = 1'b0;
    logic stalled = 1'b0;

    receive_window_reorder_buffer #(
        .WINDOW_DEPTH(WIN_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (stim),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // True when id a comes after id b, with 16-bit wraparound.
    function automatic logic seq_after(input logic [rwrb_pkg::ID_W-1:0] a,
                                       input logic [rwrb_pkg::ID_W-1:0] b);
        int x;
        int y;
        x = a;
        y = b;
        return (x > y && x - y <= 32768) || (x < y && y - x > 32768);
    endfunction

    // Works out the result of one item and updates the window state.
    function automatic rwrb_pkg::t_out resolve_item(input rwrb_pkg::t_in it);
        rwrb_pkg::t_out            r;
        logic [rwrb_pkg::ID_W-1:0] top;
        int                        s;
        r = '0;
        if (it.action == ACT_PULL) begin
            s = int'(win_next) % WIN_DEPTH;
            if (win_desync) begin
                r.status = rwrb_pkg::ST_BLOCKED;
            end else if (slot_held[s] && slot_tag[s] == win_next) begin
                r.status            = rwrb_pkg::ST_DELIVERED;
                r.delivered_id      = win_next;
                r.delivered_payload = slot_data[s];
                slot_held[s]        = 1'b0;
                win_next            = win_next + 1'b1;
            end else begin
                r.status = rwrb_pkg::ST_NONE;
            end
        end else if (win_skip) begin
            r.status = rwrb_pkg::ST_SKIPPED;
            if (it.last_in_packet) win_skip = 1'b0;
        end else begin
            top = win_next + rwrb_pkg::ID_W'(WIN_DEPTH - 1);
            s   = int'(it.message_id) % WIN_DEPTH;
            if (seq_after(win_next, it.message_id)) begin
                r.status = rwrb_pkg::ST_OLD;
            end else if (seq_after(it.message_id, top)) begin
                r.status   = rwrb_pkg::ST_DESYNC;
                win_desync = 1'b1;
                win_skip   = !it.last_in_packet;
            end else if (slot_held[s] && slot_tag[s] == it.message_id) begin
                r.status = rwrb_pkg::ST_DUP;
            end else begin
                slot_held[s] = 1'b1;
                slot_tag[s]  = it.message_id;
                slot_data[s] = it.payload_handle;
                r.status     = rwrb_pkg::ST_STORED;
            end
        end
        return r;
    endfunction

    // Mostly short gaps between items, now and then a long one.
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string why, input rwrb_pkg::t_out want,
                                   input rwrb_pkg::t_out got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected status %0d id %h payload %h, %s %0d id %h payload %h",
                     $realtime, why, want.status, want.delivered_id, want.delivered_payload,
                     "got status", got.status, got.delivered_id, got.delivered_payload);
    endtask

    task automatic queue_item(input logic act, input logic [rwrb_pkg::ID_W-1:0] id,
                              input logic [rwrb_pkg::HANDLE_BITS-1:0] pay, input logic last);
        rwrb_pkg::t_in it;
        it.action         = act;
        it.message_id     = id;
        it.payload_handle = pay;
        it.last_in_packet = last;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Sender pause: waits until every queued item has been answered.
    task automatic wait_drained();
        while ((pending_items.size() != 0 || expected_results.size() != 0) && !stalled) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    // One burst of in-window arrivals in shuffled order, with duplicates, old
    // ids and pulls mixed in. The window base is exact since the block is idle.
    task automatic queue_ordered_burst();
        logic [rwrb_pkg::ID_W-1:0] ids [16];
        logic [rwrb_pkg::ID_W-1:0] base;
        logic [rwrb_pkg::ID_W-1:0] t;
        int                        n;
        int                        total;
        int                        j;
        base  = win_next;
        n     = $urandom_range(1, 12);
        total = n;
        for (int i = 0; i < n; i++) ids[i] = base + rwrb_pkg::ID_W'(i);
        if ($urandom_range(0, 3) == 0) begin
            ids[total] = base + rwrb_pkg::ID_W'(($urandom_range(0, 2) == 0)
                                                ? WIN_DEPTH - 1
                                                : $urandom_range(n, WIN_DEPTH - 1));
            total++;
        end
        for (int i = total - 1; i > 0; i--) begin
            j      = $urandom_range(0, i);
            t      = ids[i];
            ids[i] = ids[j];
            ids[j] = t;
        end
        for (int i = 0; i < total; i++) begin
            queue_item(ACT_ARRIVE, ids[i], $urandom,
                       (i == total - 1) || ($urandom_range(0, 9) < 3));
            if ($urandom_range(0, 9) < 2)
                queue_item(ACT_PULL, rwrb_pkg::ID_W'($urandom), $urandom, 1'($urandom));
            if ($urandom_range(0, 9) == 0)
                queue_item(ACT_ARRIVE, ids[$urandom_range(0, i)], $urandom, 1'($urandom));
            if ($urandom_range(0, 11) == 0)
                queue_item(ACT_ARRIVE,
                           base - 1'b1 - rwrb_pkg::ID_W'($urandom_range(0, 32766)),
                           $urandom, 1'($urandom));
        end
        for (int i = 0; i < n + 2; i++)
            queue_item(ACT_PULL, rwrb_pkg::ID_W'($urandom), $urandom, 1'($urandom));
    endtask

    // Driver: presents the head of the pending queue at the falling edge.
    always @(negedge i_clk) begin
        if (!start || seen_count != taken_count) begin
            seen_count = taken_count;
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (stim_go && pending_items.size() != 0) begin
                start    <= 1'b1;
                stim     <= pending_items[0];
                gap_left  = next_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks results and takes in accepted items at the rising edge.
    always @(posedge i_clk) begin : monitor
        rwrb_pkg::t_out want;
        logic           took;
        if (i_rst_n) begin
            took = start && !busy;
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, o_result);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.status != want.status
                            || o_result.delivered_id != want.delivered_id
                            || o_result.delivered_payload != want.delivered_payload)
                        report_mismatch("result mismatch", want, o_result);
                end
            end
            if (took) begin
                expected_results.push_back(resolve_item(stim));
                void'(pending_items.pop_front());
                taken_count++;
            end
            if (took || o_strobe) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) stalled = 1'b1;
            end
        end
    end

    initial begin
        logic [rwrb_pkg::ID_W-1:0] base;
        logic                      act;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            slot_held[i] = 1'b0;
            slot_tag[i]  = '0;
            slot_data[i] = '0;
        end

        // Directed start: empty pull, duplicate, delivery, old ids, window top.
        queue_item(ACT_PULL,   16'h0000, 32'h0000_0000, 1'b0);
        queue_item(ACT_ARRIVE, 16'h0000, 32'hFFFF_FFFF, 1'b0);
        queue_item(ACT_ARRIVE, 16'h0000, 32'h0000_0000, 1'b1);
        queue_item(ACT_ARRIVE, 16'h0001, 32'h0000_0000, 1'b1);
        queue_item(ACT_PULL,   16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        queue_item(ACT_PULL,   16'h0000, 32'h0000_0000, 1'b0);
        queue_item(ACT_PULL,   16'h0000, 32'h0000_0000, 1'b0);
        queue_item(ACT_ARRIVE, 16'h0001, 32'h1234_5678, 1'b0);
        queue_item(ACT_ARRIVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        queue_item(ACT_ARRIVE, 16'h0401, 32'hA5A5_A5A5, 1'b1);
        queue_item(ACT_ARRIVE, 16'h0002, 32'h5A5A_5A5A, 1'b0);
        queue_item(ACT_PULL,   16'h0000, 32'h0000_0000, 1'b0);
        queue_item(ACT_PULL,   16'h0000, 32'h0000_0000, 1'b0);

        repeat (6) @(posedge i_clk);
        #1 i_rst_n = 1'b1;
        stim_go = 1'b1;

        // Ordered bursts, each begun from an idle block.
        while (items_queued < ITEMS_ORDERED && !stalled) begin
            wait_drained();
            no_idle = ($urandom_range(0, 5) == 0);
            queue_ordered_burst();
        end

        // Desync: sticky error, skipping the rest of the packet, blocked pulls.
        wait_drained();
        no_idle = 1'b0;
        base = win_next;
        queue_item(ACT_ARRIVE, base + rwrb_pkg::ID_W'(WIN_DEPTH), $urandom, 1'b0);
        queue_item(ACT_ARRIVE, base, $urandom, 1'b0);
        queue_item(ACT_ARRIVE, base + 1'b1, $urandom, 1'b1);
        queue_item(ACT_PULL, base, $urandom, 1'b0);
        queue_item(ACT_ARRIVE, base + 1'b1, $urandom, 1'b0);
        queue_item(ACT_ARRIVE, base + 1'b1, $urandom, 1'b0);
        queue_item(ACT_ARRIVE, base - 1'b1, $urandom, 1'b0);
        queue_item(ACT_ARRIVE, base + rwrb_pkg::ID_W'(WIN_DEPTH), $urandom, 1'b1);
        queue_item(ACT_ARRIVE, base + 2'd2, $urandom, 1'b1);
        queue_item(ACT_PULL, base, $urandom, 1'b1);

        // Random items after the error: the window base no longer moves.
        while (items_queued < ITEMS_TOTAL && !stalled) begin
            act = ($urandom_range(0, 9) < 3) ? ACT_PULL : ACT_ARRIVE;
            if ($urandom_range(0, 1) == 0)
                queue_item(act, base + rwrb_pkg::ID_W'($urandom_range(0, WIN_DEPTH + 64)),
                           $urandom, $urandom_range(0, 9) < 4);
            else
                queue_item(act, rwrb_pkg::ID_W'($urandom), $urandom,
                           $urandom_range(0, 9) < 4);
        end

        wait_drained();
        if (stalled) begin
            $display("simulation failed");
        end else begin
            repeat (8) @(posedge i_clk);
            if (mismatches == 0) begin
                $display("simulation ok");
            end else begin
                $display("simulation failed");
            end
        end
        $finish;
    end

endmodule
